[design/linear_adsr_envelope_defines.svh]
// Assertion macros used by the envelope generator datapath module.
`ifndef LINEAR_ADSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled during reset.
`define LAE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled during reset.
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/adsr_pkg.sv]
// Types and constants shared by the envelope generator modules.
`default_nettype none

package adsr_pkg;

    localparam int PHASE_BITS    = 3;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // Register reset values before truncation to the level width.
    localparam logic [31:0] PEAK_RESET = 32'd65535;
    localparam logic [31:0] HOLD_RESET = 32'd32768;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_PEAK    = 3'd4;
    localparam logic [2:0] REG_HOLD    = 3'd5;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic skip_step;
        logic load_mul;
        logic div_init;
        logic div_step;
        logic load_out;
    } adsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_needed;
        logic div_last;
        logic out_free;
    } adsr_status_t;

endpackage

`default_nettype wire

[design/linear_adsr_envelope.sv]
// Top level of the linear ADSR envelope generator.
//
//  Channel   Direction  Ports                          Contents
//  s_*       in         s_tvalid s_tready s_tdata      one tick: restart flag
//  m_*       out        m_tvalid m_tready m_tdata      one sample: level, phase, last
//  apb       in/out     psel penable pwrite paddr ...  six registers at 4*index
//
// An item passes from accept through phase skipping, the multiplier and the serial
// divider, one quotient bit per cycle, to the result register. The next item is
// accepted in the cycle after the result is loaded, not while the last one is worked.
// Reset is synchronous and active low; it puts the envelope in the done phase.
// A stalled result waits in the output register while the next item is worked.
`default_nettype none

module linear_adsr_envelope
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Input items.
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [0] restart
    // Result items.
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [((LEVEL_BITS+PHASE_BITS+7)/8)*8-1:0] m_tdata, // level, phase
    output logic                              m_tlast,
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0]     paddr,
    input  wire logic [CFG_DATA_BITS-1:0]     pwdata,
    output logic      [CFG_DATA_BITS-1:0]     prdata,
    output logic                              pready
);

    localparam int OUT_DATA_BITS = ((LEVEL_BITS + PHASE_BITS + 7) / 8) * 8;

    logic [3:0][COUNT_BITS-1:0] lens;
    logic [LEVEL_BITS-1:0]      peak;
    logic [LEVEL_BITS-1:0]      hold;
    adsr_cmd_t                  cmd;
    adsr_status_t               status;
    logic [LEVEL_BITS-1:0]      m_level;
    logic [PHASE_BITS-1:0]      m_phase;

    adsr_cfg #(
        .COUNT_BITS (COUNT_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .lens    (lens),
        .peak    (peak),
        .hold    (hold)
    );

    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp #(
        .COUNT_BITS (COUNT_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .restart  (s_tdata[0]),
        .lens     (lens),
        .peak     (peak),
        .hold     (hold),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_level  (m_level),
        .m_phase  (m_phase),
        .m_last   (m_tlast)
    );

    // Pack the result: level in the low bits, phase above it, zero fill.
    assign m_tdata = OUT_DATA_BITS'({m_phase, m_level});

endmodule

`default_nettype wire

[design/adsr_cfg.sv]
// APB-style configuration register file for the envelope generator.
`default_nettype none

module adsr_cfg
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0]      paddr,
    input  wire logic [CFG_DATA_BITS-1:0]      pwdata,
    output logic      [CFG_DATA_BITS-1:0]      prdata,
    output logic                               pready,
    output logic      [3:0][COUNT_BITS-1:0]    lens,
    output logic      [LEVEL_BITS-1:0]         peak,
    output logic      [LEVEL_BITS-1:0]         hold
);

    logic [3:0][COUNT_BITS-1:0] lens_reg;
    logic [LEVEL_BITS-1:0]      peak_reg;
    logic [LEVEL_BITS-1:0]      hold_reg;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lens_reg <= '0;
            peak_reg <= PEAK_RESET[LEVEL_BITS-1:0];
            hold_reg <= HOLD_RESET[LEVEL_BITS-1:0];
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ATTACK:  lens_reg[0] <= pwdata[COUNT_BITS-1:0];
                REG_DECAY:   lens_reg[1] <= pwdata[COUNT_BITS-1:0];
                REG_SUSTAIN: lens_reg[2] <= pwdata[COUNT_BITS-1:0];
                REG_RELEASE: lens_reg[3] <= pwdata[COUNT_BITS-1:0];
                REG_PEAK:    peak_reg    <= pwdata[LEVEL_BITS-1:0];
                REG_HOLD:    hold_reg    <= pwdata[LEVEL_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_ATTACK:  prdata = CFG_DATA_BITS'(lens_reg[0]);
            REG_DECAY:   prdata = CFG_DATA_BITS'(lens_reg[1]);
            REG_SUSTAIN: prdata = CFG_DATA_BITS'(lens_reg[2]);
            REG_RELEASE: prdata = CFG_DATA_BITS'(lens_reg[3]);
            REG_PEAK:    prdata = CFG_DATA_BITS'(peak_reg);
            REG_HOLD:    prdata = CFG_DATA_BITS'(hold_reg);
            default:     prdata = '0;
        endcase
    end

    assign lens = lens_reg;
    assign peak = peak_reg;
    assign hold = hold_reg;

endmodule

`default_nettype wire

[design/adsr_ctrl.sv]
// Controller state machine that sequences one envelope sample per item.
`default_nettype none

module adsr_ctrl
    import adsr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire adsr_status_t status,
    output adsr_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // No item is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Walk past empty or finished phases, one per cycle.
                if (status.skip_needed) begin
                    cmd.skip_step = 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.load_mul = 1'b1;
                state_next   = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/adsr_dp.sv]
// Datapath: phase and index state, multiplier, serial divider and output register.
`default_nettype none

`include "linear_adsr_envelope_defines.svh"

module adsr_dp
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire adsr_cmd_t                  cmd,
    output adsr_status_t                    status,
    input  wire logic                       restart,
    input  wire logic [3:0][COUNT_BITS-1:0] lens,
    input  wire logic [LEVEL_BITS-1:0]      peak,
    input  wire logic [LEVEL_BITS-1:0]      hold,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic      [LEVEL_BITS-1:0]      m_level,
    output logic      [PHASE_BITS-1:0]      m_phase,
    output logic                            m_last
);

    localparam int PROD_BITS = COUNT_BITS + LEVEL_BITS;
    localparam int DCNT_BITS = $clog2(LEVEL_BITS);

    // Envelope position.
    phase_t                  phase_reg;
    logic [COUNT_BITS-1:0]   idx_reg;

    // Multiplier and divider registers.
    logic [PROD_BITS-1:0]    prod_reg;
    logic [COUNT_BITS-1:0]   den_reg;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [LEVEL_BITS-1:0]   quo_reg;
    logic [DCNT_BITS-1:0]    dcnt_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [LEVEL_BITS-1:0]   out_level_reg;
    phase_t                  out_phase_reg;
    logic                    out_last_reg;

    logic [COUNT_BITS-1:0]   len_cur;
    logic [COUNT_BITS-1:0]   len_m1;
    logic                    len_short;
    logic [COUNT_BITS:0]     idx_p1;
    logic                    skip_needed;
    logic                    diff_neg;
    logic [LEVEL_BITS-1:0]   diff_mag;
    logic [COUNT_BITS-1:0]   mul_a;
    logic [LEVEL_BITS-1:0]   mul_b;
    logic [COUNT_BITS-1:0]   den_sel;
    logic [COUNT_BITS:0]     trial;
    logic                    trial_ge;
    logic [LEVEL_BITS-1:0]   level_next;
    logic                    later_empty;
    logic                    last_next;

    // Current phase length and derived terms.
    always_comb begin
        if (phase_reg == PH_DONE) begin
            len_cur = '0;
        end else begin
            len_cur = lens[phase_reg[1:0]];
        end
    end

    assign len_m1      = len_cur - COUNT_BITS'(1);
    assign len_short   = (len_cur[COUNT_BITS-1:1] == '0);
    assign idx_p1      = {1'b0, idx_reg} + (COUNT_BITS+1)'(1);
    assign skip_needed = (phase_reg != PH_DONE) && (idx_reg >= len_cur);
    assign diff_neg    = (hold < peak);
    assign diff_mag    = diff_neg ? (peak - hold) : (hold - peak);

    // Envelope position update on a new item and while skipping phases.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            idx_reg   <= '0;
        end else if (cmd.accept) begin
            if (restart) begin
                phase_reg <= PH_ATTACK;
                idx_reg   <= '0;
            end else if (phase_reg != PH_DONE) begin
                idx_reg <= idx_p1[COUNT_BITS-1:0];
                if (idx_p1[COUNT_BITS]) begin
                    phase_reg <= phase_t'(phase_reg + PHASE_BITS'(1));
                end
            end else begin
                idx_reg <= '0;
            end
        end else if (cmd.skip_step) begin
            phase_reg <= phase_t'(phase_reg + PHASE_BITS'(1));
            idx_reg   <= '0;
        end
    end

    // Operand selection: the quotient of a*b/den is the ramp offset.
    always_comb begin
        unique case (phase_reg)
            PH_ATTACK: begin
                mul_a   = idx_reg;
                mul_b   = peak;
                den_sel = len_m1;
            end
            PH_DECAY: begin
                mul_a   = idx_p1[COUNT_BITS-1:0];
                mul_b   = diff_mag;
                den_sel = len_cur;
            end
            default: begin
                mul_a   = idx_reg;
                mul_b   = hold;
                den_sel = len_m1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_mul) begin
            prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
            den_reg  <= den_sel;
        end
    end

    // Restoring divider, one quotient bit per cycle. The quotient never
    // exceeds the level width, so the upper product bits seed the remainder.
    assign trial    = {rem_reg, quo_reg[LEVEL_BITS-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= prod_reg[PROD_BITS-1:LEVEL_BITS];
            quo_reg <= prod_reg[LEVEL_BITS-1:0];
        end else if (cmd.div_step) begin
            if (trial_ge) begin
                rem_reg <= COUNT_BITS'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[COUNT_BITS-1:0];
            end
            quo_reg <= {quo_reg[LEVEL_BITS-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_init) begin
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + DCNT_BITS'(1);
        end
    end

    // Final level per phase.
    always_comb begin
        unique case (phase_reg)
            PH_ATTACK:  level_next = len_short ? peak : quo_reg;
            PH_DECAY:   level_next = diff_neg ? (peak - quo_reg) : (peak + quo_reg);
            PH_SUSTAIN: level_next = hold;
            PH_RELEASE: level_next = len_short ? '0 : (hold - quo_reg);
            default:    level_next = '0;
        endcase
    end

    // Last sample: end of this phase and all later phases empty.
    always_comb begin
        unique case (phase_reg)
            PH_ATTACK:  later_empty = (lens[1] == '0) && (lens[2] == '0) && (lens[3] == '0);
            PH_DECAY:   later_empty = (lens[2] == '0) && (lens[3] == '0);
            PH_SUSTAIN: later_empty = (lens[3] == '0);
            PH_RELEASE: later_empty = 1'b1;
            default:    later_empty = 1'b0;
        endcase
    end

    assign last_next = (phase_reg != PH_DONE) && (idx_p1 >= {1'b0, len_cur}) && later_empty;

    // Output register; the next item may be in work while this one waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_level_reg <= level_next;
            out_phase_reg <= phase_reg;
            out_last_reg  <= last_next;
        end
    end

    assign status.skip_needed = skip_needed;
    assign status.div_last    = (dcnt_reg == DCNT_BITS'(LEVEL_BITS - 1));
    assign status.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_level  = out_level_reg;
    assign m_phase  = out_phase_reg;
    assign m_last   = out_last_reg;

    `LAE_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !m_valid_reg || m_tready, "result overwritten before it was taken")
    `LAE_ASSERT_IMPL(a_skip_before_mul, cmd.load_mul, !skip_needed, "ramp operands taken from a finished phase")
    `LAE_ASSERT_NEXT(a_rem_below_den, cmd.div_init, (rem_reg < den_reg) || (den_reg == '0), "divider seed not below divisor")
    `LAE_ASSERT_IMPL(a_release_bound, cmd.load_out && (phase_reg == PH_RELEASE), level_next <= hold, "release level above sustain level")

endmodule

`default_nettype wire
